/* sv/b64d_pkg.sv */
// Shared types, constants and the character decode function of the base64 stream decoder.
// Used by every module of the decoder; depends on nothing else.
package b64d_pkg;

  // Queue depth between the character front end and the byte back end.
  localparam int QUEUE_DEPTH = 2;

  // ASCII codes that bound the ranges of the alphabet.
  localparam logic [7:0] CODE_UPPER_A = 8'h41;
  localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
  localparam logic [7:0] CODE_LOWER_A = 8'h61;
  localparam logic [7:0] CODE_LOWER_Z = 8'h7A;
  localparam logic [7:0] CODE_DIGIT_0 = 8'h30;
  localparam logic [7:0] CODE_DIGIT_9 = 8'h39;
  localparam logic [7:0] CODE_PLUS    = 8'h2B;
  localparam logic [7:0] CODE_SLASH   = 8'h2F;
  localparam logic [7:0] CODE_PAD     = 8'h3D;

  // Offsets that turn a code into its sextet value within each range.
  localparam logic [7:0] LOWER_OFFSET = 8'd71;  // 'a' - 26
  localparam logic [7:0] DIGIT_OFFSET = 8'd4;   // 52 - '0'
  localparam logic [5:0] PLUS_VALUE   = 6'd62;
  localparam logic [5:0] SLASH_VALUE  = 6'd63;

  typedef enum logic [1:0] {
    CHAR_DATA,
    CHAR_PAD,
    CHAR_BAD
  } char_kind_t;

  typedef struct packed {
    char_kind_t  kind;
    logic [5:0]  value;
  } sextet_t;

  // One closed group, as handed from the front end to the back end.
  typedef struct packed {
    logic [23:0] word;      // three decoded bytes, most significant first
    logic [1:0]  nbytes;    // bytes to emit; zero means the empty end marker
    logic        last;      // group ends the stream
    logic        bad;       // group held a character outside the alphabet
  } group_t;

  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t r;
    r.kind  = CHAR_BAD;
    r.value = '0;
    if (c >= CODE_UPPER_A && c <= CODE_UPPER_Z) begin
      r.kind  = CHAR_DATA;
      r.value = 6'(c - CODE_UPPER_A);
    end else if (c >= CODE_LOWER_A && c <= CODE_LOWER_Z) begin
      r.kind  = CHAR_DATA;
      r.value = 6'(c - LOWER_OFFSET);
    end else if (c >= CODE_DIGIT_0 && c <= CODE_DIGIT_9) begin
      r.kind  = CHAR_DATA;
      r.value = 6'(c + DIGIT_OFFSET);
    end else if (c == CODE_PLUS) begin
      r.kind  = CHAR_DATA;
      r.value = PLUS_VALUE;
    end else if (c == CODE_SLASH) begin
      r.kind  = CHAR_DATA;
      r.value = SLASH_VALUE;
    end else if (c == CODE_PAD) begin
      r.kind  = CHAR_PAD;
    end
    return r;
  endfunction

endpackage

/* sv/b64d_front.sv */
// Front end of the base64 stream decoder: accepts characters, classifies them and
// gathers each group of four; closed groups go to the queue. Depends on b64d_pkg.
module b64d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_ascii_char,
  input  logic             in_last_char,
  input  logic             q_ready,
  output logic             q_push,
  output b64d_pkg::group_t q_rec
);
  import b64d_pkg::*;

  logic [17:0] acc_r, acc_nxt, acc_upd;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  cnt_r, cnt_nxt, cnt_upd, cnt_less;
  logic        err_r, err_nxt, err_upd;
  sextet_t     sx;
  logic [5:0]  val;
  logic        accept;
  logic        closes;
  logic [1:0]  nbytes;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sx      = map_char(in_ascii_char);
    val     = (sx.kind == CHAR_DATA) ? sx.value : 6'd0;
    cnt_upd = cnt_r + ((sx.kind != CHAR_PAD) ? 3'd1 : 3'd0);
    err_upd = err_r || (sx.kind == CHAR_BAD);
    acc_upd = acc_r;
    case (pos_r)
      2'd0:    acc_upd[17:12] = acc_r[17:12] | val;
      2'd1:    acc_upd[11:6]  = acc_r[11:6]  | val;
      2'd2:    acc_upd[5:0]   = acc_r[5:0]   | val;
      default: acc_upd        = acc_r;
    endcase
    closes   = (pos_r == 2'd3) || in_last_char;
    cnt_less = (cnt_upd == 3'd0) ? 3'd0 : 3'(cnt_upd - 3'd1);
    nbytes   = (cnt_less > 3'd3) ? 2'd3 : cnt_less[1:0];
  end

  always_comb begin
    q_rec.word   = {acc_upd, (pos_r == 2'd3) ? val : 6'd0};
    q_rec.nbytes = nbytes;
    q_rec.last   = in_last_char;
    q_rec.bad    = err_upd;
    // A group that yields nothing and does not end the stream leaves no trace.
    q_push       = accept && closes && ((nbytes != 2'd0) || in_last_char);
  end

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (accept) begin
      if (closes) begin
        acc_nxt = '0;
        pos_nxt = '0;
        cnt_nxt = '0;
        err_nxt = 1'b0;
      end else begin
        acc_nxt = acc_upd;
        pos_nxt = 2'(pos_r + 2'd1);
        cnt_nxt = cnt_upd;
        err_nxt = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
      cnt_r <= '0;
      err_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  // The count of real characters can never run ahead of the position in the group.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= {1'b0, pos_r})
    else $error("front: real character count exceeds group position");

  // A closing character always returns the group state to zero.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && closes) |=> (pos_r == 2'd0 && cnt_r == 3'd0 && !err_r && acc_r == 18'd0))
    else $error("front: group state not cleared after close");

  // Nothing is pushed unless a character was accepted.
  a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> accept)
    else $error("front: push without an accepted character");

endmodule

/* sv/b64d_queue.sv */
// Short queue of closed groups between the front end and the back end of the decoder.
// Depends on b64d_pkg for the group record type.
module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64d_pkg::group_t push_rec,
  output logic             not_full,
  output logic             head_valid,
  output b64d_pkg::group_t head_rec,
  input  logic             pop
);
  import b64d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  group_t           slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full   = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_rec   = slots_r[rd_ptr_r];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue: occupancy above depth");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("queue: push into a full queue");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue: pop from an empty queue");

endmodule

/* sv/b64d_back.sv */
// Back end of the base64 stream decoder: unpacks each queued group into byte beats
// and holds them in the output register. Depends on b64d_pkg.
module b64d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  b64d_pkg::group_t head_rec,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_last_byte,
  output logic             out_bad_char
);
  import b64d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       has_r, has_nxt;
  logic       last_r, last_nxt;
  logic       bad_r, bad_nxt;
  logic       load;
  logic       final_beat;
  logic [7:0] sel_byte;

  assign load = head_valid && (!valid_r || out_ready);

  always_comb begin
    final_beat = (head_rec.nbytes == 2'd0) || (idx_r == 2'(head_rec.nbytes - 2'd1));
    case (idx_r)
      2'd0:    sel_byte = head_rec.word[23:16];
      2'd1:    sel_byte = head_rec.word[15:8];
      default: sel_byte = head_rec.word[7:0];
    endcase
    pop = load && final_beat;
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ready;
    byte_nxt  = byte_r;
    has_nxt   = has_r;
    last_nxt  = last_r;
    bad_nxt   = bad_r;
    if (load) begin
      valid_nxt = 1'b1;
      has_nxt   = (head_rec.nbytes != 2'd0);
      byte_nxt  = has_nxt ? sel_byte : 8'd0;
      last_nxt  = head_rec.last && final_beat;
      bad_nxt   = head_rec.bad;
      idx_nxt   = final_beat ? 2'd0 : 2'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    has_r  <= has_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_has_byte  = has_r;
  assign out_last_byte = last_r;
  assign out_bad_char  = bad_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3)
    else $error("back: byte index out of range");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !final_beat) |=> (idx_r == 2'($past(idx_r) + 2'd1)))
    else $error("back: byte index did not advance");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !has_r) |-> last_r)
    else $error("back: empty beat that does not end the stream");

endmodule

/* sv/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder: front end, group queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ascii_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last_byte,
  output logic       out_bad_char
);
  // The decoder takes one character of standard base64 text per input beat and
  // returns decoded bytes one per output beat. Characters are gathered in groups
  // of four; a group closes on its fourth character or on a character marked
  // last, and then gives one byte fewer than it held non-padding characters,
  // most significant first. Padding counts as zero and is not counted. A
  // character outside the alphabet is decoded as zero and raises bad_char on
  // every beat of its group. When the stream ends on a group that yields no
  // byte, a single beat with has_byte low and last_byte high marks the end.
  // Input beats are taken at one per cycle while the group queue has room; the
  // output register emits at most one byte beat per cycle, so the sustained
  // rate is set by the input side: a full group of four characters produces three
  // beats, so the back end keeps pace with input at one character per cycle. Each
  // closed group is first written into the queue and then loaded into the output
  // register. The queue (QUEUE_DEPTH groups) lets the character side carry on
  // while the receiver stalls, and in_ready falls only when it is full.
  import b64d_pkg::*;

  logic   q_push;
  logic   q_not_full;
  logic   q_head_valid;
  logic   q_pop;
  group_t q_push_rec;
  group_t q_head_rec;

  b64d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ascii_char (in_ascii_char),
    .in_last_char  (in_last_char),
    .q_ready       (q_not_full),
    .q_push        (q_push),
    .q_rec         (q_push_rec)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_push_rec),
    .not_full   (q_not_full),
    .head_valid (q_head_valid),
    .head_rec   (q_head_rec),
    .pop        (q_pop)
  );

  b64d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_rec      (q_head_rec),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_has_byte  (out_has_byte),
    .out_last_byte (out_last_byte),
    .out_bad_char  (out_bad_char)
  );

endmodule
